@@ rtl/msf_pkg.sv @@
// msf_pkg: shared constants for the message slot FIFO.
// Holds parameter defaults, result status codes and request codes.
// No dependencies.
`timescale 1ns / 1ps

package msf_pkg;

   localparam int SLOTS_DEF      = 16;
   localparam int SLOT_BYTES_DEF = 64;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_OVER  = 2'd3;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_READ  = 1'b1;

endpackage

@@ rtl/msf_ram.sv @@
// msf_ram: generic simple dual-port RAM, one write port and one read port.
// Read data is registered.
// No dependencies.
`timescale 1ns / 1ps

module msf_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/message_slot_fifo.sv @@
// message_slot_fifo: ring of fixed-size message slots held in two RAMs.
// Depends on msf_pkg and msf_ram.
//
// Usage:
//   The request channel (req_*) carries either one message byte to write
//   (req_type write, req_last_byte marks the end) or a request to read the
//   oldest whole message (req_type read). The result channel (rsp_*) returns
//   one transfer per written byte, one status transfer for a read of an
//   empty ring, or one transfer per byte of the message being read, with
//   rsp_last on the final one.
//   A write byte's result appears the cycle after the transfer, so writes
//   run at one byte per cycle while rsp_ready is high.
//   A read first fetches the slot length and first byte from the RAMs,
//   then streams one byte per cycle while rsp_ready is high through the
//   single read port of the byte RAM; each byte passes through the RAM's
//   read register and then the output register. The next request is taken
//   once the block is idle with no byte pending or held and the output
//   register free or transferring, so a read holds the block to its end.
//   When the receiver stalls, a two-entry buffer (output register plus a
//   hold register) absorbs the byte already in flight and byte fetches
//   pause until space frees up; nothing is lost or repeated.
//   Reset empties the ring and aborts any open message. The RAMs are not
//   cleared; only committed slots are ever read, so no clearing pass runs.
`timescale 1ns / 1ps

module message_slot_fifo #(
   parameter int SLOTS      = msf_pkg::SLOTS_DEF,
   parameter int SLOT_BYTES = msf_pkg::SLOT_BYTES_DEF,
   parameter int IDX_W      = $clog2(SLOTS),
   parameter int OFF_W      = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1,
   parameter int LEN_W      = $clog2(SLOT_BYTES + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_type,
   input  logic [7:0]       req_data_byte,
   input  logic             req_last_byte,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [7:0]       rsp_data_byte_out,
   output logic [LEN_W-1:0] rsp_msg_length,
   output logic             rsp_last
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_FIRST  = 2'd1;
   localparam logic [1:0] S_STREAM = 2'd2;

   localparam int BADDR_W = IDX_W + OFF_W;
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(SLOT_BYTES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] read_index_ff, read_index_in;
   logic [IDX_W-1:0] write_index_ff, write_index_in;
   logic [LEN_W-1:0] fill_offset_ff, fill_offset_in;
   logic             dropping_ff, dropping_in;
   logic             open_ff, open_in;

   logic [IDX_W-1:0] rd_slot_ff, rd_slot_in;
   logic [LEN_W-1:0] rd_off_ff, rd_off_in;
   logic [LEN_W-1:0] rd_len_ff, rd_len_in;
   logic             pend_ff, pend_in;
   logic [LEN_W-1:0] pend_off_ff, pend_off_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic [7:0]       rsp_data_ff, rsp_data_in;
   logic [LEN_W-1:0] rsp_len_ff, rsp_len_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             hold_valid_ff, hold_valid_in;
   logic [7:0]       hold_data_ff, hold_data_in;
   logic [LEN_W-1:0] hold_len_ff, hold_len_in;
   logic             hold_last_ff, hold_last_in;

   logic               req_fire, rsp_fire, rsp_free;
   logic [IDX_W-1:0]   wr_next, rd_next;
   logic               ring_full, ring_empty;
   logic               w_drop;
   logic [LEN_W-1:0]   w_off;
   logic [LEN_W-1:0]   w_off_next;
   logic [1:0]         w_status;
   logic               byte_we, len_we;
   logic [BADDR_W-1:0] byte_waddr, byte_raddr;
   logic               byte_re;
   logic [7:0]         byte_rdata;
   logic [LEN_W-1:0]   len_rdata;
   logic [LEN_W-1:0]   len_sel;
   logic [1:0]         occ;
   logic               issue;
   logic               pend_last;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && !pend_ff && !hold_valid_ff && rsp_free;
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid_ff && rsp_ready;

   assign wr_next    = (write_index_ff == LAST_IDX) ? '0 : write_index_ff + 1'b1;
   assign rd_next    = (read_index_ff == LAST_IDX) ? '0 : read_index_ff + 1'b1;
   assign ring_full  = (read_index_ff == wr_next);
   assign ring_empty = (read_index_ff == write_index_ff);

   // write path
   always_comb begin
      w_drop     = open_ff ? dropping_ff : ring_full;
      w_off      = open_ff ? fill_offset_ff : '0;
      w_off_next = w_off;
      byte_we    = 1'b0;
      w_status   = msf_pkg::ST_OK;
      if (w_drop) begin
         w_status = msf_pkg::ST_FULL;
      end else if (w_off < MAX_LEN) begin
         byte_we    = req_fire && (req_type == msf_pkg::REQ_WRITE);
         w_off_next = w_off + 1'b1;
      end else begin
         w_status = msf_pkg::ST_OVER;
      end
      len_we = req_fire && (req_type == msf_pkg::REQ_WRITE) && req_last_byte && !w_drop;
   end

   assign byte_waddr = {write_index_ff, w_off[OFF_W-1:0]};

   // read stream
   assign len_sel   = (state_ff == S_FIRST) ? len_rdata : rd_len_ff;
   assign occ       = {1'b0, rsp_valid_ff} + {1'b0, hold_valid_ff} + {1'b0, pend_ff};
   assign issue     = (state_ff != S_IDLE) && (rd_off_ff < len_sel)
                      && ((occ - {1'b0, rsp_fire}) < 2'd2);
   assign pend_last = ({1'b0, pend_off_ff} + 1'b1) == {1'b0, len_sel};

   always_comb begin
      byte_re    = 1'b0;
      byte_raddr = {rd_slot_ff, rd_off_ff[OFF_W-1:0]};
      if (req_fire && (req_type == msf_pkg::REQ_READ) && !ring_empty) begin
         byte_re    = 1'b1;
         byte_raddr = {read_index_ff, {OFF_W{1'b0}}};
      end else if (issue) begin
         byte_re = 1'b1;
      end
   end

   always_comb begin
      state_in       = state_ff;
      read_index_in  = read_index_ff;
      write_index_in = write_index_ff;
      fill_offset_in = fill_offset_ff;
      dropping_in    = dropping_ff;
      open_in        = open_ff;
      rd_slot_in     = rd_slot_ff;
      rd_off_in      = rd_off_ff;
      rd_len_in      = rd_len_ff;
      pend_in        = 1'b0;
      pend_off_in    = pend_off_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_len_in     = rsp_len_ff;
      rsp_last_in    = rsp_last_ff;
      hold_valid_in  = hold_valid_ff;
      hold_data_in   = hold_data_ff;
      hold_len_in    = hold_len_ff;
      hold_last_in   = hold_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && (req_type == msf_pkg::REQ_READ) && !ring_empty) begin
               state_in      = S_FIRST;
               rd_slot_in    = read_index_ff;
               read_index_in = rd_next;
               rd_off_in     = LEN_W'(1);
               pend_in       = 1'b1;
               pend_off_in   = '0;
            end
         end
         S_FIRST: begin
            rd_len_in = len_rdata;
            state_in  = S_STREAM;
         end
         S_STREAM: begin
            if ((rd_off_ff >= rd_len_ff) && !pend_ff) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (issue) begin
         pend_in     = 1'b1;
         pend_off_in = rd_off_ff;
         rd_off_in   = rd_off_ff + 1'b1;
      end

      // update fill state on a write transfer
      if (req_fire && (req_type == msf_pkg::REQ_WRITE)) begin
         if (req_last_byte) begin
            if (!w_drop) begin
               write_index_in = wr_next;
            end
            open_in        = 1'b0;
            dropping_in    = 1'b0;
            fill_offset_in = '0;
         end else begin
            open_in        = 1'b1;
            dropping_in    = w_drop;
            fill_offset_in = w_off_next;
         end
      end

      // output register and hold register
      priority if (req_fire && (req_type == msf_pkg::REQ_WRITE)) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = w_status;
         rsp_data_in   = '0;
         rsp_len_in    = '0;
         rsp_last_in   = 1'b1;
      end else if (req_fire && ring_empty) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = msf_pkg::ST_EMPTY;
         rsp_data_in   = '0;
         rsp_len_in    = '0;
         rsp_last_in   = 1'b1;
      end else if (hold_valid_ff && rsp_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = msf_pkg::ST_OK;
         rsp_data_in   = hold_data_ff;
         rsp_len_in    = hold_len_ff;
         rsp_last_in   = hold_last_ff;
         hold_valid_in = pend_ff;
         hold_data_in  = byte_rdata;
         hold_len_in   = len_sel;
         hold_last_in  = pend_last;
      end else if (pend_ff && rsp_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = msf_pkg::ST_OK;
         rsp_data_in   = byte_rdata;
         rsp_len_in    = len_sel;
         rsp_last_in   = pend_last;
      end else if (pend_ff) begin
         hold_valid_in = 1'b1;
         hold_data_in  = byte_rdata;
         hold_len_in   = len_sel;
         hold_last_in  = pend_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         read_index_ff  <= '0;
         write_index_ff <= '0;
         fill_offset_ff <= '0;
         dropping_ff    <= 1'b0;
         open_ff        <= 1'b0;
         pend_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         hold_valid_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         read_index_ff  <= read_index_in;
         write_index_ff <= write_index_in;
         fill_offset_ff <= fill_offset_in;
         dropping_ff    <= dropping_in;
         open_ff        <= open_in;
         pend_ff        <= pend_in;
         rsp_valid_ff   <= rsp_valid_in;
         hold_valid_ff  <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_slot_ff    <= rd_slot_in;
      rd_off_ff     <= rd_off_in;
      rd_len_ff     <= rd_len_in;
      pend_off_ff   <= pend_off_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_last_ff   <= rsp_last_in;
      hold_data_ff  <= hold_data_in;
      hold_len_ff   <= hold_len_in;
      hold_last_ff  <= hold_last_in;
   end

   msf_ram #(
      .WIDTH  (8),
      .DEPTH  (SLOTS << OFF_W),
      .ADDR_W (BADDR_W)
   ) u_byte_ram (
      .clock (clock),
      .we    (byte_we),
      .waddr (byte_waddr),
      .wdata (req_data_byte),
      .re    (byte_re),
      .raddr (byte_raddr),
      .rdata (byte_rdata)
   );

   msf_ram #(
      .WIDTH  (LEN_W),
      .DEPTH  (SLOTS),
      .ADDR_W (IDX_W)
   ) u_len_ram (
      .clock (clock),
      .we    (len_we),
      .waddr (write_index_ff),
      .wdata (w_off_next),
      .re    (1'b1),
      .raddr (read_index_ff),
      .rdata (len_rdata)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_data_byte_out = rsp_data_ff;
   assign rsp_msg_length    = rsp_len_ff;
   assign rsp_last          = rsp_last_ff;

`ifndef SYNTHESIS
   a_buffer_cap: assert property (@(posedge clock) disable iff (reset)
      (occ <= 2'd2))
      else $error("result buffer overrun");

   a_pend_in_stream: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff != S_IDLE))
      else $error("byte fetch outside a read stream");

   a_write_result: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_type == msf_pkg::REQ_WRITE)) |=> (rsp_valid_ff && rsp_last_ff))
      else $error("write transfer without a result");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (fill_offset_ff <= MAX_LEN))
      else $error("fill offset beyond slot size");
`endif

endmodule
